// ----- sv/obl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_pkg
// shared types and constants for the price-level order book table
// ----------------------------------------------------------------------------
package obl_pkg;

	localparam int FIELD_BITS = 40;
	localparam int MAX_ROWS   = 32;
	localparam int ADDR_BITS  = 3;
	localparam int LIMIT_BITS = 6;

	localparam logic REG_BID_SIDE = 1'b0;
	localparam logic REG_LIMIT    = 1'b1;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	localparam logic [2:0] STATUS_INSERTED = 3'd0;
	localparam logic [2:0] STATUS_REPLACED = 3'd1;
	localparam logic [2:0] STATUS_DELETED  = 3'd2;
	localparam logic [2:0] STATUS_DEL_MISS = 3'd3;
	localparam logic [2:0] STATUS_DROPPED  = 3'd4;
	localparam logic [2:0] STATUS_ROW      = 3'd5;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_REP,
		OP_INS_R,
		OP_INS_L,
		OP_DEL
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY,
		ST_READ
	} state_t;

	// per-cell compare flags against the broadcast price
	typedef struct packed {
		logic g;   // empty or price above
		logic l;   // stored and price below
		logic ge;  // stored and price at or above
		logic eq;  // stored and price equal
	} flags_t;

endpackage
`default_nettype wire

// ----- sv/order_book_level_upsert.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// order_book_level_upsert
// one side of a price-level order book held in a sorted chain of cells
// ----------------------------------------------------------------------------
// Levels sit in a row of DEPTH cells in ascending price order. An update goes
// through the transfer, a compare state in which every cell compares its
// price with the new one, and an apply state in which every cell replaces,
// shifts in a neighbor or takes the new level; its single status result then
// goes to the output register. A read streams one level per cycle out of the
// cells, best first, while the output register is free to take it. The next
// item is taken in the cycle after the last result of the current one enters
// the output register; a waiting result there does not block a new transfer.
module order_book_level_upsert
	import obl_pkg::*;
#(
	parameter int DEPTH      = 32,
	parameter int PRICE_BITS = 40,
	parameter int QTY_BITS   = 40
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_BITS-1:0]  paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  action,
	input  wire logic [FIELD_BITS-1:0] price_ticks,
	input  wire logic [FIELD_BITS-1:0] quantity_lots,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 status,
	output logic [FIELD_BITS-1:0]      level_price,
	output logic [FIELD_BITS-1:0]      level_quantity,
	output logic                       last
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int NMAX = (DEPTH < MAX_ROWS) ? DEPTH : MAX_ROWS;

	state_t state_q, state_d;

	logic                  bid_q;
	logic [LIMIT_BITS-1:0] limit_q;
	logic                  reg_idx;
	logic                  cfg_wr;

	logic [PRICE_BITS-1:0] price_q;
	logic [QTY_BITS-1:0]   qty_q;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         n_q, n_d;
	logic [CW-1:0]         rd_pos;
	logic [IW-1:0]         rd_idx;

	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [FIELD_BITS-1:0] level_price_q;
	logic [FIELD_BITS-1:0] level_quantity_q;
	logic                  last_q;

	logic                  in_xfer;
	logic                  slot_free;
	logic                  load;
	logic                  cmp_en;
	logic                  count_we;
	logic                  rd_last;
	logic [2:0]            ld_status;
	logic [FIELD_BITS-1:0] ld_price;
	logic [FIELD_BITS-1:0] ld_qty;
	logic                  ld_last;
	op_t                   op;

	logic                  any_eq;
	logic                  full;
	logic                  drop;
	logic                  q_zero;
	logic [DEPTH-1:0]      eq_vec;

	logic [PRICE_BITS-1:0] cell_price [DEPTH];
	logic [QTY_BITS-1:0]   cell_qty   [DEPTH];
	flags_t                cell_flags [DEPTH];

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_q   <= 1'b1;
			limit_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_BID_SIDE: bid_q   <= pwdata[0];
				REG_LIMIT:    limit_q <= pwdata[LIMIT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BID_SIDE: prdata = {31'd0, bid_q};
			REG_LIMIT:    prdata = {{(32 - LIMIT_BITS){1'b0}}, limit_q};
			default:      prdata = '0;
		endcase
	end

	// cell chain
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [PRICE_BITS-1:0] lp, rp;
			logic [QTY_BITS-1:0]   lq, rq;
			flags_t                lf, rf;
			if (gi == 0) begin : g_left_end
				assign lp = '0;
				assign lq = '0;
				assign lf = '0;
			end else begin : g_left
				assign lp = cell_price[gi-1];
				assign lq = cell_qty[gi-1];
				assign lf = cell_flags[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_right_end
				assign rp = '0;
				assign rq = '0;
				assign rf = '0;
			end else begin : g_right
				assign rp = cell_price[gi+1];
				assign rq = cell_qty[gi+1];
				assign rf = cell_flags[gi+1];
			end
			obl_cell #(
				.PRICE_BITS (PRICE_BITS),
				.QTY_BITS   (QTY_BITS),
				.CW         (CW),
				.IDX        (gi)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmp_en      (cmp_en),
				.op          (op),
				.count       (count_q),
				.bc_price    (price_q),
				.bc_qty      (qty_q),
				.left_price  (lp),
				.left_qty    (lq),
				.left_flags  (lf),
				.right_price (rp),
				.right_qty   (rq),
				.right_flags (rf),
				.price       (cell_price[gi]),
				.qty         (cell_qty[gi]),
				.flags       (cell_flags[gi])
			);
			assign eq_vec[gi] = cell_flags[gi].eq;
		end
	endgenerate

	assign any_eq = |eq_vec;
	assign full   = count_q == CW'(DEPTH);
	assign q_zero = qty_q == '0;
	assign drop   = full && (bid_q ? cell_flags[0].g : cell_flags[DEPTH-1].l);

	// handshake and read pointer
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign rd_pos    = bid_q ? (count_q - CW'(1) - k_q) : k_q;
	assign rd_idx    = rd_pos[IW-1:0];
	assign rd_last   = (k_q + CW'(1)) == n_q;

	always_comb begin
		n_d = count_q;
		if ((limit_q != '0) && (8'(limit_q) < 8'(count_q))) begin
			n_d = CW'(limit_q);
		end
		if (n_d > CW'(NMAX)) begin
			n_d = CW'(NMAX);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (action == ACT_UPDATE) begin
						state_d = ST_CMP;
					end else if (count_q != '0) begin
						state_d = ST_READ;
					end
				end
			end
			ST_CMP: state_d = ST_APPLY;
			ST_APPLY: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (slot_free && rd_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		cmp_en    = 1'b0;
		load      = 1'b0;
		op        = OP_NONE;
		count_we  = 1'b0;
		count_d   = count_q;
		ld_status = STATUS_ROW;
		ld_price  = '0;
		ld_qty    = '0;
		ld_last   = 1'b1;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_CMP:  cmp_en = 1'b1;
			ST_APPLY: begin
				load = slot_free;
				if (any_eq) begin
					if (q_zero) begin
						ld_status = STATUS_DELETED;
						op        = OP_DEL;
						count_d   = count_q - CW'(1);
					end else begin
						ld_status = STATUS_REPLACED;
						op        = OP_REP;
					end
				end else if (q_zero) begin
					ld_status = STATUS_DEL_MISS;
				end else if (drop) begin
					ld_status = STATUS_DROPPED;
				end else begin
					ld_status = STATUS_INSERTED;
					op        = (full && bid_q) ? OP_INS_L : OP_INS_R;
					count_d   = full ? count_q : count_q + CW'(1);
				end
				if (!slot_free) begin
					op = OP_NONE;
				end
				count_we = slot_free;
			end
			ST_READ: begin
				load     = slot_free;
				ld_price = FIELD_BITS'(cell_price[rd_idx]);
				ld_qty   = FIELD_BITS'(cell_qty[rd_idx]);
				ld_last  = rd_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_we) begin
				count_q <= count_d;
			end
			if (in_xfer) begin
				k_q <= '0;
				n_q <= n_d;
			end else if ((state_q == ST_READ) && slot_free) begin
				k_q <= k_q + CW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			price_q  <= PRICE_BITS'(price_ticks);
			qty_q    <= QTY_BITS'(quantity_lots);
		end
		if (load) begin
			status_q         <= ld_status;
			level_price_q    <= ld_price;
			level_quantity_q <= ld_qty;
			last_q           <= ld_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign level_price    = level_price_q;
	assign level_quantity = level_quantity_q;
	assign last           = last_q;

endmodule
`default_nettype wire

// ----- sv/obl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_cell
// one level slot of the sorted table; compares, shifts and replaces
// ----------------------------------------------------------------------------
module obl_cell
	import obl_pkg::*;
#(
	parameter int PRICE_BITS = 40,
	parameter int QTY_BITS   = 40,
	parameter int CW         = 6,
	parameter int IDX        = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmp_en,
	input  op_t                        op,
	input  wire logic [CW-1:0]         count,
	input  wire logic [PRICE_BITS-1:0] bc_price,
	input  wire logic [QTY_BITS-1:0]   bc_qty,
	input  wire logic [PRICE_BITS-1:0] left_price,
	input  wire logic [QTY_BITS-1:0]   left_qty,
	input  flags_t                     left_flags,
	input  wire logic [PRICE_BITS-1:0] right_price,
	input  wire logic [QTY_BITS-1:0]   right_qty,
	input  flags_t                     right_flags,
	output logic [PRICE_BITS-1:0]      price,
	output logic [QTY_BITS-1:0]        qty,
	output flags_t                     flags
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [PRICE_BITS-1:0] price_q;
	logic [QTY_BITS-1:0]   qty_q;
	flags_t                flags_q;
	flags_t                flags_d;
	logic                  stored;

	assign stored = MY_IDX < count;

	always_comb begin
		flags_d.g  = !stored || (price_q > bc_price);
		flags_d.l  = stored && (price_q < bc_price);
		flags_d.ge = stored && (price_q >= bc_price);
		flags_d.eq = stored && (price_q == bc_price);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmp_en) begin
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_REP: begin
				if (flags_q.eq) begin
					qty_q <= bc_qty;
				end
			end
			OP_INS_R: begin
				if (left_flags.g) begin
					price_q <= left_price;
					qty_q   <= left_qty;
				end else if (flags_q.g) begin
					price_q <= bc_price;
					qty_q   <= bc_qty;
				end
			end
			OP_INS_L: begin
				if (right_flags.l) begin
					price_q <= right_price;
					qty_q   <= right_qty;
				end else if (flags_q.l) begin
					price_q <= bc_price;
					qty_q   <= bc_qty;
				end
			end
			OP_DEL: begin
				if (flags_q.ge) begin
					price_q <= right_price;
					qty_q   <= right_qty;
				end
			end
			default: begin
			end
		endcase
	end

	assign price = price_q;
	assign qty   = qty_q;
	assign flags = flags_q;

endmodule
`default_nettype wire

// ----- bench/order_book_level_upsert_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_level_upsert_tb
// self-checking bench for the sorted price-level book of one order book side
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver. Every accepted item runs
// through a shadow copy of the book that predicts its status or its stream of
// level rows. A clocked monitor compares each output transfer with the oldest
// prediction. The run starts with directed inserts, replaces and deletes at
// the price and quantity extremes, including reads of an empty book. It then
// goes through random phases on both sides with several readout limits and
// with sender gaps and receiver stalls. Registers are written and read back
// over the APB port only while the book is idle.
// ----------------------------------------------------------------------------
module order_book_level_upsert_tb;
	import obl_pkg::*;

	localparam int DEPTH     = 32;
	localparam int TAIL_WAIT = 40;

	typedef struct {
		logic                  act;
		logic [FIELD_BITS-1:0] price;
		logic [FIELD_BITS-1:0] qty;
	} book_item_t;

	typedef struct {
		logic [2:0]            status;
		logic [FIELD_BITS-1:0] price;
		logic [FIELD_BITS-1:0] qty;
		logic                  last;
	} level_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_BITS-1:0]  paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = ACT_UPDATE;
	logic [FIELD_BITS-1:0] price_ticks = '0;
	logic [FIELD_BITS-1:0] quantity_lots = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            status;
	logic [FIELD_BITS-1:0] level_price;
	logic [FIELD_BITS-1:0] level_quantity;
	logic                  last;

	book_item_t    pending_items[$];
	level_result_t expected_results[$];
	level_result_t oldest_result;

	// shadow of the book and its registers
	logic [FIELD_BITS-1:0] shadow_price[DEPTH];
	logic [FIELD_BITS-1:0] shadow_qty[DEPTH];
	int                    shadow_count = 0;
	logic                  shadow_bid = 1'b1;
	logic [LIMIT_BITS-1:0] shadow_limit = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int rows_checked = 0;
	int drops_predicted = 0;

	order_book_level_upsert u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.price_ticks    (price_ticks),
		.quantity_lots  (quantity_lots),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.level_price    (level_price),
		.level_quantity (level_quantity),
		.last           (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [FIELD_BITS-1:0] rand_field();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[FIELD_BITS-1:0];
	endfunction

	function automatic void book_remove(input int pos);
		for (int i = pos; i + 1 < shadow_count; i++) begin
			shadow_price[i] = shadow_price[i + 1];
			shadow_qty[i] = shadow_qty[i + 1];
		end
		shadow_count--;
	endfunction

	// apply one item to the shadow book and queue what it should produce
	function automatic void book_apply_item(input logic act,
			input logic [FIELD_BITS-1:0] px, input logic [FIELD_BITS-1:0] qt);
		int            pos;
		int            n;
		int            idx;
		logic [2:0]    st;
		level_result_t r;
		if (act == ACT_UPDATE) begin
			pos = -1;
			for (int i = 0; i < shadow_count; i++)
				if (pos < 0 && shadow_price[i] == px)
					pos = i;
			if (pos >= 0) begin
				if (qt == '0) begin
					book_remove(pos);
					st = STATUS_DELETED;
				end else begin
					shadow_qty[pos] = qt;
					st = STATUS_REPLACED;
				end
			end else if (qt == '0) begin
				st = STATUS_DEL_MISS;
			end else if (shadow_count >= DEPTH && shadow_bid && px < shadow_price[0]) begin
				st = STATUS_DROPPED;
			end else if (shadow_count >= DEPTH && !shadow_bid &&
					px > shadow_price[shadow_count - 1]) begin
				st = STATUS_DROPPED;
			end else begin
				// full book: evict the worst end first
				if (shadow_count >= DEPTH) begin
					if (shadow_bid)
						book_remove(0);
					else
						shadow_count--;
				end
				idx = shadow_count;
				while (idx > 0 && shadow_price[idx - 1] > px) begin
					shadow_price[idx] = shadow_price[idx - 1];
					shadow_qty[idx] = shadow_qty[idx - 1];
					idx--;
				end
				shadow_price[idx] = px;
				shadow_qty[idx] = qt;
				shadow_count++;
				st = STATUS_INSERTED;
			end
			if (st == STATUS_DROPPED)
				drops_predicted++;
			r.status = st;
			r.price = '0;
			r.qty = '0;
			r.last = 1'b1;
			expected_results = {expected_results, r};
		end else begin
			n = shadow_count;
			if (shadow_limit != 0 && int'(shadow_limit) < n)
				n = int'(shadow_limit);
			if (n > MAX_ROWS)
				n = MAX_ROWS;
			for (int k = 0; k < n; k++) begin
				idx = shadow_bid ? (shadow_count - 1 - k) : k;
				r.status = STATUS_ROW;
				r.price = shadow_price[idx];
				r.qty = shadow_qty[idx];
				r.last = (k + 1 == n);
				expected_results = {expected_results, r};
			end
		end
	endfunction

	task automatic queue_item(input logic act, input logic [FIELD_BITS-1:0] px,
			input logic [FIELD_BITS-1:0] qt);
		book_item_t it;
		it.act = act;
		it.price = px;
		it.qty = qt;
		pending_items = {pending_items, it};
	endtask

	// write one register, then read it back
	task automatic apb_write(input logic idx, input logic [31:0] val);
		logic [31:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_BID_SIDE)
			shadow_bid = val[0];
		else
			shadow_limit = val[LIMIT_BITS-1:0];
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== val) begin
			$error("prdata: expected %0h, got %0h", val, rd);
			error_count++;
		end
	endtask

	// hold the sender until every transfer has gone and every result has come
	task automatic wait_idle();
		int guard;
		guard = 0;
		while ((pending_items.size() != 0 || in_valid || expected_results.size() != 0) &&
				guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_results.size() != 0) begin
			$error("results missing: %0d still expected", expected_results.size());
			error_count++;
			expected_results.delete();
		end
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_UPDATE;
			price_ticks <= '0;
			quantity_lots <= '0;
		end else begin
			if (in_valid && in_ready) begin
				book_apply_item(action, price_ticks, quantity_lots);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					action <= pending_items[0].act;
					price_ticks <= pending_items[0].price;
					quantity_lots <= pending_items[0].qty;
					pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected transfer: status %0d price %0h", status, level_price);
					error_count++;
				end else begin
					oldest_result = expected_results.pop_front();
					if (status !== oldest_result.status) begin
						$error("status: expected %0d, got %0d", oldest_result.status, status);
						error_count++;
					end
					if (level_price !== oldest_result.price) begin
						$error("level_price: expected %0h, got %0h",
							oldest_result.price, level_price);
						error_count++;
					end
					if (level_quantity !== oldest_result.qty) begin
						$error("level_quantity: expected %0h, got %0h",
							oldest_result.qty, level_quantity);
						error_count++;
					end
					if (last !== oldest_result.last) begin
						$error("last: expected %0d, got %0d", oldest_result.last, last);
						error_count++;
					end
					results_checked++;
					if (oldest_result.status == STATUS_ROW)
						rows_checked++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [FIELD_BITS-1:0] price_pool[64];
		logic [FIELD_BITS-1:0] all_ones;
		logic [FIELD_BITS-1:0] mid_px;
		logic [FIELD_BITS-1:0] px;
		logic [FIELD_BITS-1:0] qt;
		logic                  bid_cfg;
		logic [LIMIT_BITS-1:0] limit_cfg;
		int                    n_items;
		int                    pool_n;
		int                    roll;
		all_ones = '1;
		mid_px = 40'h55_5555_5555;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every status but dropped, empty reads
		queue_item(ACT_READ, '0, '0);
		queue_item(ACT_UPDATE, '0, all_ones);
		queue_item(ACT_UPDATE, all_ones, 40'd1);
		queue_item(ACT_UPDATE, mid_px, 40'hAA_AAAA_AAAA);
		queue_item(ACT_READ, all_ones, all_ones);
		queue_item(ACT_UPDATE, mid_px, 40'd7);
		queue_item(ACT_UPDATE, 40'd123, '0);
		queue_item(ACT_READ, '0, '0);
		queue_item(ACT_UPDATE, mid_px, '0);
		queue_item(ACT_UPDATE, '0, '0);
		queue_item(ACT_READ, '0, '0);
		queue_item(ACT_UPDATE, all_ones, '0);
		queue_item(ACT_READ, '0, '0);
		wait_idle();

		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: begin
					bid_cfg = 1'b1;
					limit_cfg = '0;
					send_idle_pct = 0;
					recv_stall_pct = 0;
					n_items = 90;
					pool_n = 40;
				end
				2: begin
					bid_cfg = 1'b0;
					limit_cfg = LIMIT_BITS'(MAX_ROWS);
					send_idle_pct = 48;
					recv_stall_pct = 0;
					n_items = 90;
					pool_n = 36;
				end
				3: begin
					bid_cfg = 1'b0;
					limit_cfg = LIMIT_BITS'(1);
					send_idle_pct = 0;
					recv_stall_pct = 48;
					n_items = 90;
					pool_n = 44;
				end
				4: begin
					bid_cfg = 1'b1;
					limit_cfg = LIMIT_BITS'($urandom_range(2, MAX_ROWS - 1));
					send_idle_pct = 17;
					recv_stall_pct = 17;
					n_items = 90;
					pool_n = 40;
				end
				default: begin
					bid_cfg = 1'b0;
					limit_cfg = LIMIT_BITS'($urandom_range(0, MAX_ROWS));
					send_idle_pct = 17;
					recv_stall_pct = 17;
					n_items = 100;
					pool_n = 34;
				end
			endcase
			apb_write(REG_BID_SIDE, {31'd0, bid_cfg});
			apb_write(REG_LIMIT, {26'd0, limit_cfg});
			for (int i = 0; i < pool_n; i++)
				price_pool[i] = rand_field();
			for (int i = 0; i < n_items; i++) begin
				roll = $urandom_range(99);
				if (roll < 15) begin
					queue_item(ACT_READ, rand_field(), rand_field());
				end else begin
					if ($urandom_range(99) < 88)
						px = price_pool[$urandom_range(pool_n - 1)];
					else
						px = rand_field();
					roll = $urandom_range(99);
					if (roll < 20)
						qt = '0;
					else if (roll < 24)
						qt = all_ones;
					else
						qt = rand_field();
					queue_item(ACT_UPDATE, px, qt);
				end
			end
			wait_idle();
		end

		$display("covered %0d items in six phases, both sides, limits 0 to %0d",
			items_accepted, MAX_ROWS);
		$display("checked %0d results: %0d level rows, %0d full-book drops",
			results_checked, rows_checked, drops_predicted);
		if (error_count == 0)
			$display("order_book_level_upsert_tb: done, clean");
		else
			$display("order_book_level_upsert_tb: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("order_book_level_upsert_tb: done, errors");
		$finish;
	end

endmodule
